// ===== rtl/core/spas_pkg.sv =====
// Package for the sparse polynomial add/subtract unit.
// Holds field widths, the result limit, the sequencer state type and the
// record passed from the shared merge unit back to the sequencer.
package spas_pkg;

  localparam int COEF_W       = 16;
  localparam int EXPO_W       = 16;
  localparam int ENTRY_W      = COEF_W + EXPO_W;
  localparam int RCOEF_W      = COEF_W + 1;
  localparam int RES_W        = RCOEF_W + EXPO_W;
  localparam int RESULT_LIMIT = 32;
  localparam int RES_AW       = $clog2(RESULT_LIMIT);
  localparam int RES_CW       = $clog2(RESULT_LIMIT + 1);
  localparam int MAX_TERMS_DEF = 16;

  // Register select, taken from the word address bit of the config port
  localparam logic CFG_IDX_SUBTRACT = 1'b0;

  // Input polynomial select codes
  localparam logic POLY_A = 1'b0;
  localparam logic POLY_B = 1'b1;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_MREAD,
    ST_MSTEP,
    ST_DREAD,
    ST_DLOAD,
    ST_DHOLD
  } state_t;

  typedef struct packed {
    logic                      adv_a;
    logic                      adv_b;
    logic signed [RCOEF_W-1:0] coef;
    logic [EXPO_W-1:0]         expo;
  } merge_res_t;

endpackage

// ===== rtl/core/spas_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// Used for both term stores and the result buffer; no package dependency.
module spas_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== rtl/core/spas_merge_alu.sv =====
// Shared merge unit: compares the two head exponents and forms the result
// coefficient with one 17-bit adder. Depends on spas_pkg.
module spas_merge_alu (
  input  logic [spas_pkg::ENTRY_W-1:0] a_entry,
  input  logic [spas_pkg::ENTRY_W-1:0] b_entry,
  input  logic                         a_has,
  input  logic                         b_has,
  input  logic                         sub,
  output spas_pkg::merge_res_t         res
);

  logic signed [spas_pkg::RCOEF_W-1:0] ca;
  logic signed [spas_pkg::RCOEF_W-1:0] cb;
  logic signed [spas_pkg::RCOEF_W-1:0] cb_sgn;
  logic [spas_pkg::EXPO_W-1:0]         ea;
  logic [spas_pkg::EXPO_W-1:0]         eb;
  logic                                use_a;
  logic                                use_b;

  always_comb begin
    ca     = spas_pkg::RCOEF_W'($signed(a_entry[spas_pkg::COEF_W-1:0]));
    cb     = spas_pkg::RCOEF_W'($signed(b_entry[spas_pkg::COEF_W-1:0]));
    cb_sgn = sub ? -cb : cb;
    ea     = a_entry[spas_pkg::ENTRY_W-1:spas_pkg::COEF_W];
    eb     = b_entry[spas_pkg::ENTRY_W-1:spas_pkg::COEF_W];

    priority if (a_has && b_has) begin
      use_a = (ea >= eb);
      use_b = (ea <= eb);
    end else if (a_has) begin
      use_a = 1'b1;
      use_b = 1'b0;
    end else begin
      use_a = 1'b0;
      use_b = b_has;
    end

    res.adv_a = use_a;
    res.adv_b = use_b;
    res.coef  = (use_a ? ca : '0) + (use_b ? cb_sgn : '0);
    res.expo  = use_a ? ea : eb;
  end

endmodule

// ===== rtl/core/sparse_poly_add_sub_unit.sv =====
// Top level of the sparse polynomial add/subtract unit: term stores,
// merge sequencer, result buffer and output register.
// Depends on spas_pkg, spas_ram and spas_merge_alu.
//
//  channel | dir  | tdata                      | tuser                  | tlast
//  in_     | in   | coefficient, exponent      | poly_select            | last_term
//  out_    | out  | result_coef, result_exp    | result_empty, overflow | result_last
//  cfg_    | in   | APB, subtract_mode at 0x0  | -                      | -
//
// Loading accepts one term per cycle; the last term of B starts the merge.
// A merge step is a term store read, then a compare/add; it consumes one
// head term, or one from each store on equal exponents, and a closing step
// finds both stores spent. Each result item is read out of the result buffer
// via ST_DREAD, ST_DLOAD and ST_DHOLD (the empty marker goes straight to
// ST_DHOLD) and is held until out_tready. in_tready is low from merge start
// until the final result item is taken. Reset is synchronous and clears all
// counts; the stores need no clearing since only written entries are read.
module sparse_poly_add_sub_unit #(
  parameter int MAX_TERMS = spas_pkg::MAX_TERMS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  // input item
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [15:0] coefficient, [31:16] exponent
  input  logic [0:0]  in_tuser,   // [0] poly_select
  input  logic        in_tlast,
  // result item
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [16:0] result_coefficient, [32:17] result_exponent
  output logic [1:0]  out_tuser,  // [0] result_empty, [1] overflow (input store or result buffer)
  output logic        out_tlast,
  // configuration
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam int AW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int CW = $clog2(MAX_TERMS + 1);
  localparam int EW = spas_pkg::RES_CW;

  spas_pkg::state_t state_r, state_nxt;

  logic [CW-1:0] a_cnt_r, a_cnt_nxt;
  logic [CW-1:0] b_cnt_r, b_cnt_nxt;
  logic [CW-1:0] a_pos_r, a_pos_nxt;
  logic [CW-1:0] b_pos_r, b_pos_nxt;
  logic [EW-1:0] emit_r, emit_nxt;
  logic [EW-1:0] rd_pos_r, rd_pos_nxt;
  logic          ovf_r, ovf_nxt;
  logic          sub_r;

  logic signed [spas_pkg::RCOEF_W-1:0] out_coef_r, out_coef_nxt;
  logic [spas_pkg::EXPO_W-1:0]         out_expo_r, out_expo_nxt;
  logic                                out_last_r, out_last_nxt;
  logic                                out_empty_r, out_empty_nxt;
  logic                                out_ovf_r, out_ovf_nxt;

  logic                         in_acc;
  logic                         cfg_wr;
  logic [spas_pkg::ENTRY_W-1:0] in_entry;
  logic                         a_we;
  logic                         b_we;
  logic [spas_pkg::ENTRY_W-1:0] a_rdata;
  logic [spas_pkg::ENTRY_W-1:0] b_rdata;
  logic                         res_we;
  logic [spas_pkg::RES_W-1:0]   res_wdata;
  logic [spas_pkg::RES_W-1:0]   res_rdata;
  logic                         a_has;
  logic                         b_has;
  spas_pkg::merge_res_t         mres;

  assign in_tready = (state_r == spas_pkg::ST_LOAD);
  assign in_acc    = in_tvalid && in_tready;
  assign in_entry  = {in_tdata[31:16], in_tdata[15:0]};
  assign a_we      = in_acc && (in_tuser[0] == spas_pkg::POLY_A) && (a_cnt_r < CW'(MAX_TERMS));
  assign b_we      = in_acc && (in_tuser[0] == spas_pkg::POLY_B) && (b_cnt_r < CW'(MAX_TERMS));
  assign a_has     = (a_pos_r < a_cnt_r);
  assign b_has     = (b_pos_r < b_cnt_r);

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == spas_pkg::CFG_IDX_SUBTRACT) ? {31'd0, sub_r} : 32'd0;

  spas_ram #(.WIDTH(spas_pkg::ENTRY_W), .DEPTH(MAX_TERMS)) u_a_store (
    .clk   (clk),
    .we    (a_we),
    .waddr (a_cnt_r[AW-1:0]),
    .wdata (in_entry),
    .raddr (a_pos_r[AW-1:0]),
    .rdata (a_rdata)
  );

  spas_ram #(.WIDTH(spas_pkg::ENTRY_W), .DEPTH(MAX_TERMS)) u_b_store (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_cnt_r[AW-1:0]),
    .wdata (in_entry),
    .raddr (b_pos_r[AW-1:0]),
    .rdata (b_rdata)
  );

  spas_merge_alu u_alu (
    .a_entry (a_rdata),
    .b_entry (b_rdata),
    .a_has   (a_has),
    .b_has   (b_has),
    .sub     (sub_r),
    .res     (mres)
  );

  assign res_wdata = {mres.expo, mres.coef};
  assign res_we    = (state_r == spas_pkg::ST_MSTEP) && (a_has || b_has) &&
                     (mres.coef != '0) && (emit_r < EW'(spas_pkg::RESULT_LIMIT));

  spas_ram #(.WIDTH(spas_pkg::RES_W), .DEPTH(spas_pkg::RESULT_LIMIT)) u_res_buf (
    .clk   (clk),
    .we    (res_we),
    .waddr (emit_r[spas_pkg::RES_AW-1:0]),
    .wdata (res_wdata),
    .raddr (rd_pos_r[spas_pkg::RES_AW-1:0]),
    .rdata (res_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    a_cnt_nxt     = a_cnt_r;
    b_cnt_nxt     = b_cnt_r;
    a_pos_nxt     = a_pos_r;
    b_pos_nxt     = b_pos_r;
    emit_nxt      = emit_r;
    rd_pos_nxt    = rd_pos_r;
    ovf_nxt       = ovf_r;
    out_coef_nxt  = out_coef_r;
    out_expo_nxt  = out_expo_r;
    out_last_nxt  = out_last_r;
    out_empty_nxt = out_empty_r;
    out_ovf_nxt   = out_ovf_r;

    unique case (state_r)
      spas_pkg::ST_LOAD: begin
        if (in_acc) begin
          if (a_we) begin
            a_cnt_nxt = a_cnt_r + 1'b1;
          end else if (b_we) begin
            b_cnt_nxt = b_cnt_r + 1'b1;
          end else begin
            // store full: drop the term
            ovf_nxt = 1'b1;
          end
          if (in_tuser[0] == spas_pkg::POLY_B && in_tlast) begin
            state_nxt = spas_pkg::ST_MREAD;
          end
        end
      end
      spas_pkg::ST_MREAD: begin
        state_nxt = spas_pkg::ST_MSTEP;
      end
      spas_pkg::ST_MSTEP: begin
        if (a_has || b_has) begin
          if (mres.adv_a) a_pos_nxt = a_pos_r + 1'b1;
          if (mres.adv_b) b_pos_nxt = b_pos_r + 1'b1;
          if (mres.coef != '0) begin
            if (res_we) emit_nxt = emit_r + 1'b1;
            else        ovf_nxt  = 1'b1;
          end
          state_nxt = spas_pkg::ST_MREAD;
        end else if (emit_r == '0) begin
          // everything cancelled: hand out the empty marker
          out_coef_nxt  = '0;
          out_expo_nxt  = '0;
          out_last_nxt  = 1'b1;
          out_empty_nxt = 1'b1;
          out_ovf_nxt   = ovf_r;
          state_nxt     = spas_pkg::ST_DHOLD;
        end else begin
          state_nxt = spas_pkg::ST_DREAD;
        end
      end
      spas_pkg::ST_DREAD: begin
        state_nxt = spas_pkg::ST_DLOAD;
      end
      spas_pkg::ST_DLOAD: begin
        out_coef_nxt  = res_rdata[spas_pkg::RCOEF_W-1:0];
        out_expo_nxt  = res_rdata[spas_pkg::RES_W-1:spas_pkg::RCOEF_W];
        out_last_nxt  = (EW'(rd_pos_r + 1'b1) == emit_r);
        out_empty_nxt = 1'b0;
        out_ovf_nxt   = ovf_r;
        state_nxt     = spas_pkg::ST_DHOLD;
      end
      spas_pkg::ST_DHOLD: begin
        if (out_tready) begin
          if (out_last_r) begin
            // run done: clear for the next pair
            a_cnt_nxt  = '0;
            b_cnt_nxt  = '0;
            a_pos_nxt  = '0;
            b_pos_nxt  = '0;
            emit_nxt   = '0;
            rd_pos_nxt = '0;
            ovf_nxt    = 1'b0;
            state_nxt  = spas_pkg::ST_LOAD;
          end else begin
            rd_pos_nxt = rd_pos_r + 1'b1;
            state_nxt  = spas_pkg::ST_DREAD;
          end
        end
      end
      default: begin
        state_nxt = spas_pkg::ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= spas_pkg::ST_LOAD;
      a_cnt_r  <= '0;
      b_cnt_r  <= '0;
      a_pos_r  <= '0;
      b_pos_r  <= '0;
      emit_r   <= '0;
      rd_pos_r <= '0;
      ovf_r    <= 1'b0;
      sub_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      a_cnt_r  <= a_cnt_nxt;
      b_cnt_r  <= b_cnt_nxt;
      a_pos_r  <= a_pos_nxt;
      b_pos_r  <= b_pos_nxt;
      emit_r   <= emit_nxt;
      rd_pos_r <= rd_pos_nxt;
      ovf_r    <= ovf_nxt;
      if (cfg_wr && cfg_paddr[2] == spas_pkg::CFG_IDX_SUBTRACT) begin
        sub_r <= cfg_pwdata[0];
      end
    end
  end

  always_ff @(posedge clk) begin
    out_coef_r  <= out_coef_nxt;
    out_expo_r  <= out_expo_nxt;
    out_last_r  <= out_last_nxt;
    out_empty_r <= out_empty_nxt;
    out_ovf_r   <= out_ovf_nxt;
  end

  assign out_tvalid = (state_r == spas_pkg::ST_DHOLD);
  assign out_tdata  = {7'd0, out_expo_r, out_coef_r};
  assign out_tuser  = {out_ovf_r, out_empty_r};
  assign out_tlast  = out_last_r;

endmodule
